### rtl/core/psc_pkg.sv
package psc_pkg;

  // field widths
  localparam int RawW     = 24;
  localparam int CalW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int TempOutW = 16;
  localparam int PresW    = 18;
  localparam int DepthW   = 16;
  localparam int ByteW    = 8;

  // internal widths
  localparam int DtW    = 25;           // d2 - c5*256
  localparam int ProdW  = 42;           // dt times a calibration word
  localparam int DtSqW  = 48;           // dt squared
  localparam int TempW  = 19;           // first order temperature
  localparam int TwoW   = 17;           // second order temperature term
  localparam int SqW    = 36;           // squared temperature offsets
  localparam int CorrW  = 39;           // off2 and sens2
  localparam int CompW  = 41;           // corrected off and sens
  localparam int SplitLo = 20;          // low part of sens in the pressure product
  localparam int NumW   = 64;
  localparam int PrW    = NumW - 36;
  localparam int DzW    = 23;
  localparam int RecipW = 19;
  localparam int DpW    = DzW + RecipW;
  localparam int DqW    = DpW - 24;
  localparam int QfW    = 2 * DepthW;

  // shifts of the compensation formulas
  localparam int TempShift  = 23;
  localparam int OffShift   = 7;
  localparam int SensShift  = 8;
  localparam int T2LoShift  = 33;
  localparam int T2HiShift  = 37;
  localparam int PresShift  = 36;
  localparam int OffScale   = 21;
  localparam int DepthShift = 24;
  localparam int SplitShift = 23;

  localparam int TempRef   = 2000;
  localparam int TempLow   = -1500;
  localparam int PressTrim = 20;
  localparam int DepthZero = 79500;
  localparam int PresMax   = 262143;

  // 100/10091.0429 in q8.24
  localparam logic signed [RecipW-1:0] DepthRecip = 19'sd166258;
  // ceil(2^23/200), exact for magnitudes up to 32768
  localparam logic [DepthW-1:0] SplitRecip = 16'd41944;

  localparam logic signed [TempOutW-1:0] TempOutMax = 16'sh7FFF;
  localparam logic signed [TempOutW-1:0] TempOutMin = 16'sh8000;
  localparam logic signed [DepthW-1:0]   DepthMax   = 16'sh7FFF;
  localparam logic signed [DepthW-1:0]   DepthMin   = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_SENS = 3'd0,
    CFG_PRESS_OFF  = 3'd1,
    CFG_SENS_TC    = 3'd2,
    CFG_OFF_TC     = 3'd3,
    CFG_REF_TEMP   = 3'd4,
    CFG_TEMP_COEFF = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CalW-1:0] pressure_sensitivity;
    logic [CalW-1:0] pressure_offset;
    logic [CalW-1:0] sensitivity_temp_coeff;
    logic [CalW-1:0] offset_temp_coeff;
    logic [CalW-1:0] reference_temperature;
    logic [CalW-1:0] temperature_coeff;
  } cal_t;

  localparam cal_t CalReset = '{
    pressure_sensitivity:   16'd45269,
    pressure_offset:        16'd40405,
    sensitivity_temp_coeff: 16'd28588,
    offset_temp_coeff:      16'd27134,
    reference_temperature:  16'd32441,
    temperature_coeff:      16'd28742
  };

  typedef struct packed {
    logic [RawW-1:0]            d1;
    logic signed [TempOutW-1:0] temp;
    logic signed [CompW-1:0]    off;
    logic signed [CompW-1:0]    sens;
  } comp_t;

  typedef struct packed {
    logic signed [TempOutW-1:0] temp;
    logic [PresW-1:0]           p;
  } press_t;

endpackage

### rtl/core/pressure_sensor_compensation_unit.sv
// latency: 15 cycles from an accepted input word to its result word at the output
// throughput: one word per cycle, 15 register stages, each stage holds while stalled
// a stalled output only blocks the input once every stage holds a word
// reset: pipeline empties, calibration words return to their defaults
// calibration may be rewritten only while the pipeline is empty
module pressure_sensor_compensation_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [psc_pkg::CalW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [psc_pkg::RawW-1:0]            raw_pressure_i,
  input  logic [psc_pkg::RawW-1:0]            raw_temperature_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [psc_pkg::TempOutW-1:0] temperature_centi_o,
  output logic [psc_pkg::PresW-1:0]           pressure_tenth_mbar_o,
  output logic signed [psc_pkg::DepthW-1:0]   depth_cm_o,
  output logic [psc_pkg::ByteW-1:0]           depth_high_byte_o,
  output logic [psc_pkg::ByteW-1:0]           depth_low_byte_o
);
  import psc_pkg::*;

  cal_t   cal_d, cal_q;
  comp_t  comp;
  press_t press;
  logic   comp_valid, comp_ready;
  logic   press_valid, press_ready;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PRESS_SENS: cal_d.pressure_sensitivity   = cfg_data_i;
        CFG_PRESS_OFF:  cal_d.pressure_offset        = cfg_data_i;
        CFG_SENS_TC:    cal_d.sensitivity_temp_coeff = cfg_data_i;
        CFG_OFF_TC:     cal_d.offset_temp_coeff      = cfg_data_i;
        CFG_REF_TEMP:   cal_d.reference_temperature  = cfg_data_i;
        CFG_TEMP_COEFF: cal_d.temperature_coeff      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CalReset;
    end else begin
      cal_q <= cal_d;
    end
  end

  pscu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (comp_valid),
    .out_ready_i       (comp_ready),
    .comp_o            (comp)
  );

  pscu_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (comp_valid),
    .in_ready_o  (comp_ready),
    .comp_i      (comp),
    .out_valid_o (press_valid),
    .out_ready_i (press_ready),
    .press_o     (press)
  );

  pscu_depth u_depth (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (press_valid),
    .in_ready_o            (press_ready),
    .press_i               (press),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .temperature_centi_o   (temperature_centi_o),
    .pressure_tenth_mbar_o (pressure_tenth_mbar_o),
    .depth_cm_o            (depth_cm_o),
    .depth_high_byte_o     (depth_high_byte_o),
    .depth_low_byte_o      (depth_low_byte_o)
  );

endmodule

### rtl/core/pscu_front.sv
module pscu_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  psc_pkg::cal_t            cal_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [psc_pkg::RawW-1:0] raw_pressure_i,
  input  logic [psc_pkg::RawW-1:0] raw_temperature_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output psc_pkg::comp_t           comp_o
);
  import psc_pkg::*;

  localparam int NumStages = 6;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  // stage 1
  logic signed [DtW-1:0] dt_d, dt1_q;
  logic [RawW-1:0]       d1_1_q;
  // stage 2
  logic signed [ProdW-1:0] tprod_d, oprod_d, sprod_d;
  logic signed [ProdW-1:0] tprod2_q, oprod2_q, sprod2_q;
  logic signed [2*DtW-1:0] dtsq_d;
  logic [DtSqW-1:0]        dtsq2_q;
  logic [RawW-1:0]         d1_2_q;
  // stage 3
  logic signed [ProdW:0]   tnum, onum, snum, tbias, obias, sbias;
  logic [DtSqW+1:0]        dtsq3;
  logic [DtSqW+2:0]        dtsq7;
  logic signed [TempW-1:0] temp3_q;
  logic signed [CompW-1:0] off3_q, sens3_q;
  logic [TwoW-1:0]         t2lo3_q, t2hi3_q;
  logic [RawW-1:0]         d1_3_q;
  // stage 4
  logic signed [TempW:0]     tm, tl;
  logic signed [2*TempW+1:0] ddf, eef;
  logic [SqW-1:0]            dd4_q, ee4_q;
  logic                      below_ref4_q, below_low4_q;
  logic [TwoW-1:0]           t2_4_q;
  logic signed [TempW-1:0]   temp4_q;
  logic signed [CompW-1:0]   off4_q, sens4_q;
  logic [RawW-1:0]           d1_4_q;
  // stage 5
  logic [SqW:0]               dd3;
  logic [SqW+1:0]             dd5;
  logic [SqW+2:0]             ee7;
  logic [CorrW-1:0]           off2_d, sens2_d, off2_5_q, sens2_5_q;
  logic signed [TempW:0]      tf;
  logic signed [TempOutW-1:0] tsat, temp5_q;
  logic signed [CompW-1:0]    off5_q, sens5_q;
  logic [RawW-1:0]            d1_5_q;
  // stage 6
  comp_t comp6_q;

  // a stage takes a new word when it is empty or its word moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign comp_o      = comp6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: dT
  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cal_i.reference_temperature, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dt1_q  <= dt_d;
      d1_1_q <= raw_pressure_i;
    end
  end

  // stage 2: products with dT
  assign tprod_d = dt1_q * $signed({1'b0, cal_i.temperature_coeff});
  assign oprod_d = dt1_q * $signed({1'b0, cal_i.offset_temp_coeff});
  assign sprod_d = dt1_q * $signed({1'b0, cal_i.sensitivity_temp_coeff});
  assign dtsq_d  = dt1_q * dt1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      tprod2_q <= tprod_d;
      oprod2_q <= oprod_d;
      sprod2_q <= sprod_d;
      dtsq2_q  <= DtSqW'(dtsq_d);
      d1_2_q   <= d1_1_q;
    end
  end

  // stage 3: first order terms, truncated toward zero
  always_comb begin
    tnum  = ((ProdW+1)'(TempRef) <<< TempShift) + (ProdW+1)'(tprod2_q);
    onum  = (ProdW+1)'({cal_i.pressure_offset, 23'b0}) + (ProdW+1)'(oprod2_q);
    snum  = (ProdW+1)'({cal_i.pressure_sensitivity, 23'b0}) + (ProdW+1)'(sprod2_q);
    tbias = tnum + (tnum[ProdW] ? (ProdW+1)'(2**TempShift - 1) : '0);
    obias = onum + (onum[ProdW] ? (ProdW+1)'(2**OffShift - 1) : '0);
    sbias = snum + (snum[ProdW] ? (ProdW+1)'(2**SensShift - 1) : '0);
    dtsq3 = {2'b00, dtsq2_q} + {1'b0, dtsq2_q, 1'b0};
    dtsq7 = {dtsq2_q, 3'b000} - {3'b000, dtsq2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      temp3_q <= TempW'(tbias >>> TempShift);
      off3_q  <= CompW'(obias >>> OffShift);
      sens3_q <= CompW'(sbias >>> SensShift);
      t2lo3_q <= TwoW'(dtsq3 >> T2LoShift);
      t2hi3_q <= TwoW'(dtsq7 >> T2HiShift);
      d1_3_q  <= d1_2_q;
    end
  end

  // stage 4: temperature band and squared offsets
  assign tm  = (TempW+1)'(temp3_q) - (TempW+1)'(TempRef);
  assign tl  = (TempW+1)'(temp3_q) - (TempW+1)'(TempLow);
  assign ddf = tm * tm;
  assign eef = tl * tl;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dd4_q        <= SqW'(ddf);
      ee4_q        <= SqW'(eef);
      below_ref4_q <= temp3_q < TempRef;
      below_low4_q <= temp3_q < TempLow;
      t2_4_q       <= (temp3_q < TempRef) ? t2lo3_q : t2hi3_q;
      temp4_q      <= temp3_q;
      off4_q       <= off3_q;
      sens4_q      <= sens3_q;
      d1_4_q       <= d1_3_q;
    end
  end

  // stage 5: second order corrections
  always_comb begin
    dd3 = {1'b0, dd4_q} + {dd4_q, 1'b0};
    dd5 = {2'b00, dd4_q} + {dd4_q, 2'b00};
    ee7 = {ee4_q, 3'b000} - {3'b000, ee4_q};
    if (below_ref4_q) begin
      off2_d  = CorrW'(dd3 >> 1) + (below_low4_q ? ee7 : '0);
      sens2_d = CorrW'(dd5 >> 3) + (below_low4_q ? CorrW'({ee4_q, 2'b00}) : '0);
    end else begin
      off2_d  = CorrW'(dd4_q >> 4);
      sens2_d = '0;
    end
    tf = (TempW+1)'(temp4_q) - $signed({3'b000, t2_4_q});
    if (tf < TempOutMin) begin
      tsat = TempOutMin;
    end else if (tf > TempOutMax) begin
      tsat = TempOutMax;
    end else begin
      tsat = TempOutW'(tf);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      off2_5_q  <= off2_d;
      sens2_5_q <= sens2_d;
      temp5_q   <= tsat;
      off5_q    <= off4_q;
      sens5_q   <= sens4_q;
      d1_5_q    <= d1_4_q;
    end
  end

  // stage 6: corrected offset and sensitivity
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      comp6_q.d1   <= d1_5_q;
      comp6_q.temp <= temp5_q;
      comp6_q.off  <= off5_q - $signed({2'b00, off2_5_q});
      comp6_q.sens <= sens5_q - $signed({2'b00, sens2_5_q});
    end
  end

endmodule

### rtl/core/pscu_press.sv
module pscu_press (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psc_pkg::comp_t  comp_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psc_pkg::press_t press_o
);
  import psc_pkg::*;

  localparam int NumStages = 3;
  localparam int PplW = RawW + SplitLo;
  localparam int PphW = RawW + 1 + CompW - SplitLo;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  // stage 7
  logic [PplW-1:0]            ppl_d, ppl7_q;
  logic signed [PphW-1:0]     pph_d, pph7_q;
  logic signed [CompW-1:0]    off7_q;
  logic signed [TempOutW-1:0] temp7_q;
  // stage 8
  logic signed [NumW-1:0]     num_d, num8_q;
  logic signed [TempOutW-1:0] temp8_q;
  // stage 9
  logic signed [PrW-1:0]      pr;
  logic [PresW-1:0]           psat;
  press_t                     press9_q;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign press_o     = press9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // d1*sens as two partial products on the low and high part of sens
  assign ppl_d = comp_i.d1 * comp_i.sens[SplitLo-1:0];
  assign pph_d = $signed({1'b0, comp_i.d1}) * $signed(comp_i.sens[CompW-1:SplitLo]);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ppl7_q  <= ppl_d;
      pph7_q  <= pph_d;
      off7_q  <= comp_i.off;
      temp7_q <= comp_i.temp;
    end
  end

  assign num_d = (NumW'(pph7_q) <<< SplitLo) + NumW'(ppl7_q)
               - (NumW'(off7_q) <<< OffScale);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      num8_q  <= num_d;
      temp8_q <= temp7_q;
    end
  end

  // floor shift, trim, clamp to the field range
  always_comb begin
    pr = PrW'(num8_q >>> PresShift) + PrW'(PressTrim);
    if (pr < 0) begin
      psat = '0;
    end else if (pr > PresMax) begin
      psat = PresW'(PresMax);
    end else begin
      psat = PresW'(pr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      press9_q.p    <= psat;
      press9_q.temp <= temp8_q;
    end
  end

endmodule

### rtl/core/pscu_depth.sv
module pscu_depth (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  psc_pkg::press_t                    press_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [psc_pkg::TempOutW-1:0] temperature_centi_o,
  output logic [psc_pkg::PresW-1:0]          pressure_tenth_mbar_o,
  output logic signed [psc_pkg::DepthW-1:0]  depth_cm_o,
  output logic [psc_pkg::ByteW-1:0]          depth_high_byte_o,
  output logic [psc_pkg::ByteW-1:0]          depth_low_byte_o
);
  import psc_pkg::*;

  localparam int NumStages = 6;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;
  press_t               pass_q [NumStages];

  // stage 10
  logic signed [DzW-1:0]    dz_d, dz10_q;
  // stage 11
  logic signed [DpW-1:0]    dp_d, dp11_q;
  // stage 12
  logic signed [DpW-1:0]    dbias;
  logic signed [DqW-1:0]    dq;
  logic signed [DepthW-1:0] dsat, depth12_q;
  // stage 13
  logic signed [DepthW-1:0] depth13_q;
  logic [DepthW-1:0]        mag13_q;
  logic                     neg13_q;
  // stage 14
  logic signed [DepthW-1:0] depth14_q;
  logic [DepthW-1:0]        mag14_q;
  logic                     neg14_q;
  logic [QfW-1:0]           qf14_q;
  // stage 15
  logic [ByteW-1:0]         q8;
  logic [DepthW-1:0]        q200;
  logic [ByteW-1:0]         r8;
  logic signed [DepthW-1:0] depth15_q;
  logic [ByteW-1:0]         hi15_q, lo15_q;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // temperature and pressure ride along with the depth
  always_ff @(posedge clk_i) begin
    if (en[0]) pass_q[0] <= press_i;
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) pass_q[k] <= pass_q[k-1];
    end
  end

  // stage 10: 10p - zero point
  assign dz_d = $signed(DzW'({press_i.p, 3'b000})) + $signed(DzW'({press_i.p, 1'b0}))
              - DzW'(DepthZero);

  always_ff @(posedge clk_i) begin
    if (en[0]) dz10_q <= dz_d;
  end

  // stage 11: scale by the q8.24 reciprocal
  assign dp_d = dz10_q * DepthRecip;

  always_ff @(posedge clk_i) begin
    if (en[1]) dp11_q <= dp_d;
  end

  // stage 12: truncate toward zero and clamp
  always_comb begin
    dbias = dp11_q + (dp11_q[DpW-1] ? DpW'(2**DepthShift - 1) : '0);
    dq    = DqW'(dbias >>> DepthShift);
    if (dq < DepthMin) begin
      dsat = DepthMin;
    end else if (dq > DepthMax) begin
      dsat = DepthMax;
    end else begin
      dsat = DepthW'(dq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) depth12_q <= dsat;
  end

  // stage 13: magnitude for the base 200 split
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      depth13_q <= depth12_q;
      neg13_q   <= depth12_q[DepthW-1];
      mag13_q   <= depth12_q[DepthW-1] ? DepthW'(~depth12_q + 1'b1) : DepthW'(depth12_q);
    end
  end

  // stage 14: quotient by reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      depth14_q <= depth13_q;
      neg14_q   <= neg13_q;
      mag14_q   <= mag13_q;
      qf14_q    <= mag13_q * SplitRecip;
    end
  end

  // stage 15: remainder and sign, both round toward zero
  always_comb begin
    q8   = ByteW'(qf14_q >> SplitShift);
    q200 = DepthW'({q8, 7'b0}) + DepthW'({q8, 6'b0}) + DepthW'({q8, 3'b0});
    r8   = ByteW'(mag14_q - q200);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      depth15_q <= depth14_q;
      hi15_q    <= neg14_q ? ByteW'(~q8 + 1'b1) : q8;
      lo15_q    <= neg14_q ? ByteW'(~r8 + 1'b1) : r8;
    end
  end

  assign temperature_centi_o   = pass_q[NumStages-1].temp;
  assign pressure_tenth_mbar_o = pass_q[NumStages-1].p;
  assign depth_cm_o            = depth15_q;
  assign depth_high_byte_o     = hi15_q;
  assign depth_low_byte_o      = lo15_q;

endmodule

### rtl/core/pscu_checker.sv
module pscu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [psc_pkg::TempOutW-1:0] temperature_centi_o,
  input logic [psc_pkg::PresW-1:0]           pressure_tenth_mbar_o,
  input logic signed [psc_pkg::DepthW-1:0]   depth_cm_o,
  input logic [psc_pkg::ByteW-1:0]           depth_high_byte_o,
  input logic [psc_pkg::ByteW-1:0]           depth_low_byte_o
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(depth_cm_o)
      && $stable(pressure_tenth_mbar_o) && $stable(temperature_centi_o)
      && $stable(depth_high_byte_o) && $stable(depth_low_byte_o))
    else $error("result word changed while stalled");

  // positive depth splits into quotient up to 163 and remainder below 200
  a_split_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !depth_cm_o[15] |-> depth_high_byte_o <= 8'd163 && depth_low_byte_o < 8'd200)
    else $error("depth split out of range");

  // zero point of the depth scale
  a_depth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_tenth_mbar_o == 18'd7950 |-> depth_cm_o == 16'sd0)
    else $error("depth not zero at reference pressure");

  // below the reference pressure depth never goes positive
  a_depth_shallow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_tenth_mbar_o < 18'd7950 |-> depth_cm_o[15] || depth_cm_o == 16'sd0)
    else $error("positive depth above the surface");

endmodule

bind pressure_sensor_compensation_unit pscu_checker u_pscu_checker (.*);
